// ----- design/wtss_pkg.sv -----
// Shared types, constants and functions for the weight to seven-segment decoder.
// Used by wtss_bcd_conv, weight_to_seven_segment and the testbench; depends on nothing.
package wtss_pkg;

  // Field widths
  localparam int unsigned BIN_W    = 17;
  localparam int unsigned DIGITS   = 5;
  localparam int unsigned BCD_W    = 4 * DIGITS;
  localparam int unsigned DABBLE_W = BCD_W + BIN_W;
  localparam int unsigned SEG_W    = 8;

  // Largest magnitude the display can show (99.999 kg)
  localparam logic [BIN_W-1:0] MAG_LIMIT = 17'd99999;

  // Shift-and-add-3 steps spread over the conversion stages (17 in total)
  localparam int unsigned NUM_STAGES = 3;
  localparam int unsigned MAX_STEPS  = 6;
  localparam int unsigned STAGE_STEPS [NUM_STAGES] = '{6, 6, 5};

  // Segment bit map of this display
  localparam logic [SEG_W-1:0] SEG_A   = 8'h20;
  localparam logic [SEG_W-1:0] SEG_B   = 8'h80;
  localparam logic [SEG_W-1:0] SEG_C   = 8'h01;
  localparam logic [SEG_W-1:0] SEG_D   = 8'h02;
  localparam logic [SEG_W-1:0] SEG_E   = 8'h08;
  localparam logic [SEG_W-1:0] SEG_F   = 8'h10;
  localparam logic [SEG_W-1:0] SEG_G   = 8'h40;
  localparam logic [SEG_W-1:0] SEG_DOT = 8'h04;
  localparam logic [SEG_W-1:0] SEG_OFF = 8'h00;

  typedef logic [BIN_W-1:0]    bin_t;
  typedef logic [BCD_W-1:0]    bcd_t;
  typedef logic [DABBLE_W-1:0] dabble_t;
  typedef logic [SEG_W-1:0]    seg_t;

  // Flags that travel alongside the digits
  typedef struct packed {
    logic neg;
    logic zero;
  } side_t;

  // One double-dabble step: add 3 to every digit of five or more, then shift
  function automatic dabble_t dabble_step(dabble_t v);
    dabble_t r;
    r = v;
    for (int k = 0; k < DIGITS; k++) begin
      if (r[BIN_W + 4*k +: 4] >= 4'd5) begin
        r[BIN_W + 4*k +: 4] = r[BIN_W + 4*k +: 4] + 4'd3;
      end
    end
    return {r[DABBLE_W-2:0], 1'b0};
  endfunction

  // Apply a number of steps, at most MAX_STEPS
  function automatic dabble_t dabble_run(dabble_t v, int unsigned steps);
    dabble_t r;
    r = v;
    for (int unsigned i = 0; i < MAX_STEPS; i++) begin
      if (i < steps) begin
        r = dabble_step(r);
      end
    end
    return r;
  endfunction

  // Segment pattern of one decimal digit
  function automatic seg_t seg_glyph(logic [3:0] d);
    seg_t s;
    unique case (d)
      4'd0:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      4'd1:    s = SEG_B | SEG_C;
      4'd2:    s = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
      4'd3:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
      4'd4:    s = SEG_B | SEG_C | SEG_F | SEG_G;
      4'd5:    s = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
      4'd6:    s = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd7:    s = SEG_A | SEG_B | SEG_C;
      4'd8:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd9:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      default: s = SEG_OFF;
    endcase
    return s;
  endfunction

endpackage

// ----- design/wtss_bcd_conv.sv -----
// Pipelined binary to BCD converter (double dabble over NUM_STAGES stages).
// Depends on wtss_pkg for widths, step counts and the step function.
module wtss_bcd_conv (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wtss_pkg::bin_t   in_bin,
  input  wtss_pkg::side_t  in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output wtss_pkg::bcd_t   out_bcd,
  output wtss_pkg::side_t  out_side
);

  logic              valid   [wtss_pkg::NUM_STAGES];
  wtss_pkg::dabble_t data    [wtss_pkg::NUM_STAGES];
  wtss_pkg::side_t   side    [wtss_pkg::NUM_STAGES];
  logic              advance [wtss_pkg::NUM_STAGES];
  logic              up_valid [wtss_pkg::NUM_STAGES];
  wtss_pkg::dabble_t up_data  [wtss_pkg::NUM_STAGES];
  wtss_pkg::side_t   up_side  [wtss_pkg::NUM_STAGES];

  // A stage loads when it is empty or its content moves on
  always_comb begin
    advance[wtss_pkg::NUM_STAGES-1] = !valid[wtss_pkg::NUM_STAGES-1] || out_ready;
    for (int k = wtss_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      advance[k] = !valid[k] || advance[k+1];
    end
  end

  // Route each stage's upstream transaction
  always_comb begin
    up_valid[0] = in_valid;
    up_data[0]  = {{wtss_pkg::BCD_W{1'b0}}, in_bin};
    up_side[0]  = in_side;
    for (int k = 1; k < wtss_pkg::NUM_STAGES; k++) begin
      up_valid[k] = valid[k-1];
      up_data[k]  = data[k-1];
      up_side[k]  = side[k-1];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < wtss_pkg::NUM_STAGES; k++) begin
        valid[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < wtss_pkg::NUM_STAGES; k++) begin
        if (advance[k]) begin
          valid[k] <= up_valid[k];
        end
      end
    end
  end

  // Payload: run this stage's share of the dabble steps
  always_ff @(posedge clk) begin
    for (int k = 0; k < wtss_pkg::NUM_STAGES; k++) begin
      if (advance[k] && up_valid[k]) begin
        data[k] <= wtss_pkg::dabble_run(up_data[k], wtss_pkg::STAGE_STEPS[k]);
        side[k] <= up_side[k];
      end
    end
  end

  assign in_ready  = advance[0];
  assign out_valid = valid[wtss_pkg::NUM_STAGES-1];
  assign out_bcd   = data[wtss_pkg::NUM_STAGES-1][wtss_pkg::DABBLE_W-1 -: wtss_pkg::BCD_W];
  assign out_side  = side[wtss_pkg::NUM_STAGES-1];

  // A stalled last stage keeps its digits
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bcd) && $stable(out_side))
    else $error("conversion stage lost or changed a stalled transaction");

  // Every digit of the result is a decimal digit
  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_bcd[19:16] <= 4'd9 && out_bcd[15:12] <= 4'd9 &&
                  out_bcd[11:8] <= 4'd9 && out_bcd[7:4] <= 4'd9 && out_bcd[3:0] <= 4'd9)
    else $error("conversion produced a digit above nine");

endmodule

// ----- design/weight_to_seven_segment.sv -----
// Top level of the weight to seven-segment decoder: saturate, convert, encode.
// Depends on wtss_pkg and wtss_bcd_conv.
// Pipeline: saturate, 3 dabble stages and encode, each ending in a register.
// Throughput: one transaction per cycle while out_ready is high; a stall holds every full stage in place.
// Reset: synchronous active-high rst clears all valid bits; no result is pending after it.
module weight_to_seven_segment (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 is_negative,
  input  logic [16:0]          magnitude_thousandths,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           digit_one_segments,
  output logic [7:0]           digit_two_segments,
  output logic [7:0]           digit_three_segments,
  output logic [7:0]           digit_four_segments,
  output logic [7:0]           digit_five_segments
);

  logic            sat_valid;
  wtss_pkg::bin_t  sat_mag;
  wtss_pkg::side_t sat_side;
  logic            sat_advance;

  logic            conv_in_ready;
  logic            conv_valid;
  wtss_pkg::bcd_t  conv_bcd;
  wtss_pkg::side_t conv_side;
  logic            out_advance;

  wtss_pkg::seg_t  seg_one_next;
  wtss_pkg::seg_t  seg_two_next;
  wtss_pkg::seg_t  seg_three_next;
  wtss_pkg::seg_t  seg_four_next;
  wtss_pkg::seg_t  seg_five_next;

  // Saturate stage
  assign sat_advance = !sat_valid || conv_in_ready;
  assign in_ready    = sat_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_valid <= 1'b0;
    end else if (sat_advance) begin
      sat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sat_advance && in_valid) begin
      sat_mag       <= (magnitude_thousandths > wtss_pkg::MAG_LIMIT) ?
                       wtss_pkg::MAG_LIMIT : magnitude_thousandths;
      sat_side.neg  <= is_negative;
      sat_side.zero <= (magnitude_thousandths == '0);
    end
  end

  wtss_bcd_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sat_valid),
    .in_ready  (conv_in_ready),
    .in_bin    (sat_mag),
    .in_side   (sat_side),
    .out_valid (conv_valid),
    .out_ready (out_advance),
    .out_bcd   (conv_bcd),
    .out_side  (conv_side)
  );

  // Encode digits into segment bytes; a zero leading digit is blanked, or shows a minus sign when negative
  always_comb begin
    if (conv_side.zero && !conv_side.neg) begin
      seg_one_next   = wtss_pkg::SEG_OFF;
      seg_two_next   = wtss_pkg::SEG_OFF;
      seg_three_next = wtss_pkg::SEG_OFF;
      seg_four_next  = wtss_pkg::SEG_OFF;
      seg_five_next  = wtss_pkg::seg_glyph(4'd0);
    end else begin
      if (conv_bcd[19:16] != 4'd0) begin
        seg_one_next = wtss_pkg::seg_glyph(conv_bcd[19:16]);
      end else if (conv_side.neg) begin
        seg_one_next = wtss_pkg::SEG_G;
      end else begin
        seg_one_next = wtss_pkg::SEG_OFF;
      end
      seg_two_next   = wtss_pkg::seg_glyph(conv_bcd[15:12]) | wtss_pkg::SEG_DOT;
      seg_three_next = wtss_pkg::seg_glyph(conv_bcd[11:8]);
      seg_four_next  = wtss_pkg::seg_glyph(conv_bcd[7:4]);
      seg_five_next  = wtss_pkg::seg_glyph(conv_bcd[3:0]);
    end
  end

  // Output register
  assign out_advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= conv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && conv_valid) begin
      digit_one_segments   <= seg_one_next;
      digit_two_segments   <= seg_two_next;
      digit_three_segments <= seg_three_next;
      digit_four_segments  <= seg_four_next;
      digit_five_segments  <= seg_five_next;
    end
  end

  // Saturate stage holds while the converter is full
  a_sat_hold: assert property (@(posedge clk) disable iff (rst)
    sat_valid && !conv_in_ready |=> sat_valid && $stable(sat_mag) && $stable(sat_side))
    else $error("saturate stage dropped a stalled transaction");

  // Saturated magnitude never exceeds the display range
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    sat_valid |-> sat_mag <= wtss_pkg::MAG_LIMIT)
    else $error("magnitude not saturated");

  // A blank unit digit only occurs on the zero display
  a_zero_display: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_two_segments == wtss_pkg::SEG_OFF |->
      digit_one_segments == wtss_pkg::SEG_OFF && digit_three_segments == wtss_pkg::SEG_OFF &&
      digit_four_segments == wtss_pkg::SEG_OFF)
    else $error("zero display shows stray segments");

  // Otherwise the unit digit carries the decimal point
  a_unit_dot: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_two_segments != wtss_pkg::SEG_OFF |->
      (digit_two_segments & wtss_pkg::SEG_DOT) == wtss_pkg::SEG_DOT)
    else $error("unit digit missing decimal point");

endmodule

// ----- tb/segment_display_checker.sv -----
// Checker for the weight to seven-segment decoder: watches both channels,
// predicts each display from the accepted weight and compares it on arrival.
// Depends on wtss_pkg for widths and the segment bit map.
module segment_display_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             is_negative,
  input  wtss_pkg::bin_t   magnitude_thousandths,
  input  logic             out_valid,
  input  logic             out_ready,
  input  wtss_pkg::seg_t   digit_one_segments,
  input  wtss_pkg::seg_t   digit_two_segments,
  input  wtss_pkg::seg_t   digit_three_segments,
  input  wtss_pkg::seg_t   digit_four_segments,
  input  wtss_pkg::seg_t   digit_five_segments,
  output int               failures,
  output int               pending_displays
);

  typedef struct packed {
    wtss_pkg::seg_t one;
    wtss_pkg::seg_t two;
    wtss_pkg::seg_t three;
    wtss_pkg::seg_t four;
    wtss_pkg::seg_t five;
  } display_t;

  display_t expected_displays [$];
  int       mismatch_total = 0;

  // Segment pattern of one decimal digit in this display's bit map
  function automatic wtss_pkg::seg_t digit_glyph(int unsigned d);
    wtss_pkg::seg_t s;
    case (d)
      0:       s = wtss_pkg::SEG_A | wtss_pkg::SEG_B | wtss_pkg::SEG_C | wtss_pkg::SEG_D |
                   wtss_pkg::SEG_E | wtss_pkg::SEG_F;
      1:       s = wtss_pkg::SEG_B | wtss_pkg::SEG_C;
      2:       s = wtss_pkg::SEG_A | wtss_pkg::SEG_B | wtss_pkg::SEG_D | wtss_pkg::SEG_E |
                   wtss_pkg::SEG_G;
      3:       s = wtss_pkg::SEG_A | wtss_pkg::SEG_B | wtss_pkg::SEG_C | wtss_pkg::SEG_D |
                   wtss_pkg::SEG_G;
      4:       s = wtss_pkg::SEG_B | wtss_pkg::SEG_C | wtss_pkg::SEG_F | wtss_pkg::SEG_G;
      5:       s = wtss_pkg::SEG_A | wtss_pkg::SEG_C | wtss_pkg::SEG_D | wtss_pkg::SEG_F |
                   wtss_pkg::SEG_G;
      6:       s = wtss_pkg::SEG_A | wtss_pkg::SEG_C | wtss_pkg::SEG_D | wtss_pkg::SEG_E |
                   wtss_pkg::SEG_F | wtss_pkg::SEG_G;
      7:       s = wtss_pkg::SEG_A | wtss_pkg::SEG_B | wtss_pkg::SEG_C;
      8:       s = wtss_pkg::SEG_A | wtss_pkg::SEG_B | wtss_pkg::SEG_C | wtss_pkg::SEG_D |
                   wtss_pkg::SEG_E | wtss_pkg::SEG_F | wtss_pkg::SEG_G;
      default: s = wtss_pkg::SEG_A | wtss_pkg::SEG_B | wtss_pkg::SEG_C | wtss_pkg::SEG_D |
                   wtss_pkg::SEG_F | wtss_pkg::SEG_G;
    endcase
    return s;
  endfunction

  // Work out the five segment bytes for one signed weight
  function automatic display_t predict_display(logic neg, wtss_pkg::bin_t raw);
    int unsigned mag;
    int unsigned whole;
    display_t    d;
    mag = (raw > wtss_pkg::MAG_LIMIT) ? int'(wtss_pkg::MAG_LIMIT) : int'(raw);
    d   = '0;
    // Positive zero: a lone zero on the last digit, no decimal point
    if (mag == 0 && !neg) begin
      d.five = digit_glyph(0);
      return d;
    end
    whole = mag / 1000;
    if (whole >= 10) begin
      d.one = digit_glyph(whole / 10);
    end else if (neg) begin
      d.one = wtss_pkg::SEG_G;
    end else begin
      d.one = wtss_pkg::SEG_OFF;
    end
    d.two   = digit_glyph(whole % 10) | wtss_pkg::SEG_DOT;
    d.three = digit_glyph((mag / 100) % 10);
    d.four  = digit_glyph((mag / 10) % 10);
    d.five  = digit_glyph(mag % 10);
    return d;
  endfunction

  function automatic int compare_digit(string name, wtss_pkg::seg_t exp_seg,
                                       wtss_pkg::seg_t act_seg);
    if (exp_seg !== act_seg) begin
      $display("%0t: %s expected %h, actual %h", $time, name, exp_seg, act_seg);
      return 1;
    end
    return 0;
  endfunction

  // Pop and compare results first, then record new weights
  always @(posedge clk) begin
    display_t exp_d;
    int       bad;
    if (rst) begin
      expected_displays.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_displays.size() == 0) begin
          $display("%0t: unexpected display %h %h %h %h %h", $time,
                   digit_one_segments, digit_two_segments, digit_three_segments,
                   digit_four_segments, digit_five_segments);
          mismatch_total = mismatch_total + 1;
        end else begin
          exp_d = expected_displays.pop_front();
          bad   = 0;
          bad   = bad + compare_digit("digit_one", exp_d.one, digit_one_segments);
          bad   = bad + compare_digit("digit_two", exp_d.two, digit_two_segments);
          bad   = bad + compare_digit("digit_three", exp_d.three, digit_three_segments);
          bad   = bad + compare_digit("digit_four", exp_d.four, digit_four_segments);
          bad   = bad + compare_digit("digit_five", exp_d.five, digit_five_segments);
          if (bad != 0) begin
            mismatch_total = mismatch_total + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_displays.push_back(predict_display(is_negative, magnitude_thousandths));
      end
    end
    failures         <= mismatch_total;
    pending_displays <= expected_displays.size();
  end

endmodule

// ----- tb/weight_to_seven_segment_tb.sv -----
// Top of the weight to seven-segment testbench: clock, reset, weight stimulus
// and result back-pressure. Depends on wtss_pkg, the block and segment_display_checker.
module weight_to_seven_segment_tb;

  logic           clk                   = 1'b0;
  logic           rst                   = 1'b1;
  logic           in_valid              = 1'b0;
  logic           is_negative           = 1'b0;
  wtss_pkg::bin_t magnitude_thousandths = '0;
  logic           out_ready             = 1'b0;
  logic           in_ready;
  logic           out_valid;
  wtss_pkg::seg_t digit_one_segments;
  wtss_pkg::seg_t digit_two_segments;
  wtss_pkg::seg_t digit_three_segments;
  wtss_pkg::seg_t digit_four_segments;
  wtss_pkg::seg_t digit_five_segments;
  int             failures;
  int             pending_displays;
  int             idle_max = 10;

  weight_to_seven_segment DUT (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .is_negative           (is_negative),
    .magnitude_thousandths (magnitude_thousandths),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .digit_one_segments    (digit_one_segments),
    .digit_two_segments    (digit_two_segments),
    .digit_three_segments  (digit_three_segments),
    .digit_four_segments   (digit_four_segments),
    .digit_five_segments   (digit_five_segments)
  );

  segment_display_checker u_checker (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .is_negative           (is_negative),
    .magnitude_thousandths (magnitude_thousandths),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .digit_one_segments    (digit_one_segments),
    .digit_two_segments    (digit_two_segments),
    .digit_three_segments  (digit_three_segments),
    .digit_four_segments   (digit_four_segments),
    .digit_five_segments   (digit_five_segments),
    .failures              (failures),
    .pending_displays      (pending_displays)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Present one weight after a random gap and hold it until the transaction
  task automatic send_weight(input logic neg, input int unsigned mag);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    is_negative           <= neg;
    magnitude_thousandths <= wtss_pkg::bin_t'(mag);
    do @(posedge clk); while (!in_ready);
  endtask

  // Weights spread over every display form, with a share above saturation
  function automatic int unsigned pick_magnitude();
    int unsigned band;
    band = $urandom_range(0, 99);
    if (band < 5)  return 0;
    if (band < 30) return $urandom_range(1, 999);
    if (band < 55) return $urandom_range(1000, 9999);
    if (band < 85) return $urandom_range(10000, 99999);
    return $urandom_range(100000, 131071);
  endfunction

  // Stall the result side at random, one draw per result transaction
  initial begin
    int unsigned stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, idle_max);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int unsigned directed [];
    int          drain;
    directed = '{0, 1, 5, 999, 1000, 1001, 9999, 10000, 12345, 67890,
                 98765, 99999, 100000, 131071, 43210};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero of both signs, sub-kilogram negatives, saturation
    foreach (directed[i]) begin
      send_weight(1'b0, directed[i]);
      send_weight(1'b1, directed[i]);
    end

    // Random weights, in stretches that each idle or not at random
    for (int n = 0; n < 1400; n++) begin
      if (n % 150 == 0) begin
        idle_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      end
      send_weight(1'($urandom_range(0, 1)), pick_magnitude());
    end
    in_valid <= 1'b0;
    idle_max = 10;

    // Drain outstanding results, then allow for the pipeline depth
    @(posedge clk);
    drain = 0;
    while (pending_displays != 0 && drain < 100000) begin
      @(posedge clk);
      drain = drain + 1;
    end
    repeat (20) @(posedge clk);
    if (failures == 0 && pending_displays == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
